// File: rtl/irq_subscription_router_defines.svh
// Assertion macros used by the interrupt subscription router request sequencer.
`ifndef IRQ_SUBSCRIPTION_ROUTER_DEFINES_SVH
`define IRQ_SUBSCRIPTION_ROUTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IRQSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irqsr same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IRQSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irqsr next-cycle check failed");

`endif

// File: rtl/irqsr_pkg.sv
// Types, codes and constants of the interrupt subscription router.
`default_nettype none
package irqsr_pkg;

  localparam int LINE_W        = 6;
  localparam int VID_W         = 32;
  localparam int IRQ_LINES_DEF = 32;

  localparam logic [1:0] REQ_SUBSCRIBE   = 2'd0;
  localparam logic [1:0] REQ_UNSUBSCRIBE = 2'd1;
  localparam logic [1:0] REQ_EVENT       = 2'd2;
  localparam logic [1:0] REQ_FAILURE     = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;
  localparam logic [1:0] ST_NOPERM  = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [LINE_W-1:0] irq_line;
    logic [VID_W-1:0]  requester_vid;
  } irq_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             forward;
    logic [VID_W-1:0] target_vid;
  } irq_rsp_t;

  // Owner table port: one read and one write per cycle.
  typedef struct packed {
    logic              re;
    logic [LINE_W-1:0] raddr;
    logic              we;
    logic [LINE_W-1:0] waddr;
    logic [VID_W-1:0]  wdata;
  } tbl_req_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_LOOKUP
  } fsm_t;

endpackage
`default_nettype wire

// File: rtl/irqsr_table.sv
// Owner table: synchronous memory with per-entry valid bits cleared at reset.
`default_nettype none
module irqsr_table #(
  parameter int IRQ_LINES = irqsr_pkg::IRQ_LINES_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  irqsr_pkg::tbl_req_t          tbl_req,
  output logic [irqsr_pkg::VID_W-1:0]  rd_owner
);

  localparam int AW = (IRQ_LINES > 1) ? $clog2(IRQ_LINES) : 1;

  logic [irqsr_pkg::VID_W-1:0] mem_r [IRQ_LINES];
  logic [IRQ_LINES-1:0]        vld_r;
  logic [irqsr_pkg::VID_W-1:0] rd_data_r;
  logic                        rd_vld_r;

  always_ff @(posedge clk) begin
    if (tbl_req.we) begin
      mem_r[tbl_req.waddr[AW-1:0]] <= tbl_req.wdata;
    end
    if (tbl_req.re) begin
      rd_data_r <= mem_r[tbl_req.raddr[AW-1:0]];
      rd_vld_r  <= vld_r[tbl_req.raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (tbl_req.we) begin
      vld_r[tbl_req.waddr[AW-1:0]] <= 1'b1;
    end
  end

  // Never-written entries read as free.
  assign rd_owner = rd_vld_r ? rd_data_r : '0;

endmodule
`default_nettype wire

// File: rtl/irqsr_ctrl.sv
// Request sequencer: table lookup, ownership decision, write-back and result register.
`default_nettype none
`include "irq_subscription_router_defines.svh"
module irqsr_ctrl #(
  parameter int IRQ_LINES = irqsr_pkg::IRQ_LINES_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  irqsr_pkg::irq_req_t          in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output irqsr_pkg::irq_rsp_t          out_data,
  output irqsr_pkg::tbl_req_t          tbl_req,
  input  wire [irqsr_pkg::VID_W-1:0]   rd_owner
);

  irqsr_pkg::fsm_t     state_r, state_nxt;
  irqsr_pkg::irq_req_t req_r;
  irqsr_pkg::irq_rsp_t out_r, rsp;
  logic                out_valid_r, out_valid_nxt;
  logic                slot_free, load_out, in_range, wr_en;
  logic [irqsr_pkg::VID_W-1:0] wr_data;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_range  = {1'b0, req_r.irq_line} < (irqsr_pkg::LINE_W + 1)'(IRQ_LINES);

  // Ownership decision on the owner read back from the table.
  always_comb begin
    rsp     = '0;
    wr_en   = 1'b0;
    wr_data = '0;
    if (!in_range) begin
      rsp.status = irqsr_pkg::ST_INVALID;
    end else begin
      case (req_r.req_type)
        irqsr_pkg::REQ_SUBSCRIBE: begin
          if (rd_owner == '0 || rd_owner == req_r.requester_vid) begin
            wr_en   = 1'b1;
            wr_data = req_r.requester_vid;
          end else begin
            rsp.status = irqsr_pkg::ST_BUSY;
          end
        end
        irqsr_pkg::REQ_UNSUBSCRIBE: begin
          if (rd_owner == req_r.requester_vid) begin
            wr_en = 1'b1;
          end else begin
            rsp.status = irqsr_pkg::ST_NOPERM;
          end
        end
        irqsr_pkg::REQ_EVENT: begin
          if (rd_owner != '0) begin
            rsp.forward    = 1'b1;
            rsp.target_vid = rd_owner;
          end
        end
        default: begin
          wr_en = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      irqsr_pkg::FSM_IDLE: begin
        if (in_valid) state_nxt = irqsr_pkg::FSM_LOOKUP;
      end
      irqsr_pkg::FSM_LOOKUP: begin
        if (slot_free) state_nxt = irqsr_pkg::FSM_IDLE;
      end
      default: state_nxt = irqsr_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    load_out      = 1'b0;
    tbl_req       = '0;
    tbl_req.raddr = in_data.irq_line;
    tbl_req.waddr = req_r.irq_line;
    tbl_req.wdata = wr_data;
    case (state_r)
      irqsr_pkg::FSM_IDLE: begin
        in_stall   = 1'b0;
        tbl_req.re = in_valid;
      end
      irqsr_pkg::FSM_LOOKUP: begin
        load_out   = slot_free;
        tbl_req.we = slot_free && wr_en;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= irqsr_pkg::FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_req.re) req_r <= in_data;
    if (load_out)   out_r <= rsp;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `IRQSR_ASSERT_NEXT(a_accept_to_lookup, in_valid && !in_stall, state_r == irqsr_pkg::FSM_LOOKUP)
  `IRQSR_ASSERT_NOW(a_write_in_lookup, tbl_req.we, state_r == irqsr_pkg::FSM_LOOKUP && load_out)
  `IRQSR_ASSERT_NOW(a_fwd_ok, out_valid && out_data.forward, out_data.status == irqsr_pkg::ST_OK)
  `IRQSR_ASSERT_NOW(a_nofwd_zero, out_valid && !out_data.forward, out_data.target_vid == '0)
  `IRQSR_ASSERT_NEXT(a_result_after_lookup, load_out, out_valid)

endmodule
`default_nettype wire

// File: rtl/irq_subscription_router.sv
// Interrupt subscription router top level: owner table and request sequencer.
// Flow: an accepted request is registered together with its table read, then the decision
// and write-back follow; a new request is taken only after the previous write-back.
// A full result register stalls the sequencer, not the table; a new request enters
// while the previous result still waits only after its write-back.
// Reset: synchronous active-low; clears the per-line valid bits at once, no clearing pass.
`default_nettype none
module irq_subscription_router #(
  parameter int IRQ_LINES = irqsr_pkg::IRQ_LINES_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  irqsr_pkg::irq_req_t  in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output irqsr_pkg::irq_rsp_t  out_data
);

  irqsr_pkg::tbl_req_t         tbl_req;
  logic [irqsr_pkg::VID_W-1:0] rd_owner;

  irqsr_table #(
    .IRQ_LINES (IRQ_LINES)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .tbl_req  (tbl_req),
    .rd_owner (rd_owner)
  );

  irqsr_ctrl #(
    .IRQ_LINES (IRQ_LINES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .tbl_req   (tbl_req),
    .rd_owner  (rd_owner)
  );

endmodule
`default_nettype wire
